/* sv/npcc_pkg.sv */
// Shared types and constants for the nearest palette color classifier.
// No dependencies; every other file of the block depends on this package.
package npcc_pkg;

    localparam int COLOR_W = 8;
    localparam int CLASS_W = 8;
    localparam int CMD_W   = 2;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;

    // Request commands. The fourth code is ignored by the block.
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_APPEND   = 2'd1,
        CMD_CLASSIFY = 2'd2
    } npcc_cmd_t;

    // One stored reference color with its class code.
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [CLASS_W-1:0] cls;
    } npcc_entry_t;

    // Marks that travel with one table read through the scan pipeline.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } npcc_tag_t;

    // Running minimum reported by the distance unit.
    typedef struct packed {
        logic               done;
        logic [DIST_W-1:0]  min_dist;
        logic [CLASS_W-1:0] cls;
    } npcc_best_t;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_WAIT = 3'b100
    } npcc_state_t;

endpackage

/* sv/npcc_if.sv */
// Valid/ready channel interfaces for the request and result streams.
// Depends on npcc_pkg for the field widths.
interface npcc_in_if;
    logic                               valid;
    logic                               ready;
    logic [npcc_pkg::CMD_W-1:0]         cmd;
    logic [npcc_pkg::COLOR_W-1:0]       red;
    logic [npcc_pkg::COLOR_W-1:0]       green;
    logic [npcc_pkg::COLOR_W-1:0]       blue;
    logic [npcc_pkg::CLASS_W-1:0]       entry_class;

    modport source (output valid, output cmd, output red, output green, output blue,
                    output entry_class, input ready);
    modport sink   (input valid, input cmd, input red, input green, input blue,
                    input entry_class, output ready);
endinterface

interface npcc_out_if;
    logic                               valid;
    logic                               ready;
    logic [npcc_pkg::CLASS_W-1:0]       chosen_class;
    logic [npcc_pkg::DIST_W-1:0]        best_distance;
    logic                               used_fallback;
    logic                               table_full;

    modport source (output valid, output chosen_class, output best_distance,
                    output used_fallback, output table_full, input ready);
    modport sink   (input valid, input chosen_class, input best_distance,
                    input used_fallback, input table_full, output ready);
endinterface

/* sv/nearest_palette_color_classifier_top.sv */
// Top level of the nearest palette color classifier: sequencer, fill count and result register.
// Depends on npcc_pkg, npcc_if, npcc_table and npcc_dist.
//
//   Channel   Direction  Handshake      Payload
//   item      in         valid/ready    cmd, red, green, blue, entry_class
//   result    out        valid/ready    chosen_class, best_distance, used_fallback, table_full
//   cfg       in         cfg_we only    cfg_wdata -> fallback_class
//
// A clear, an append or a classify on an empty table completes in the idle state.
// A classify on a table of N entries scans the table: the single table read port and the
// shared distance unit handle one entry per cycle, then the read, square and compare stages
// drain and the minimum is loaded into the result register.
// Reset clears the fill count and the fallback class at once; the table memory is not cleared.
// A new request is taken in the idle state when the result register is empty or being read.
module nearest_palette_color_classifier_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [npcc_pkg::CLASS_W-1:0]  cfg_wdata,
    npcc_in_if.sink                       item,
    npcc_out_if.source                    result
);
    import npcc_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    npcc_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [CLASS_W-1:0] fallback_reg;
    logic [COLOR_W-1:0] q_red_reg, q_red_next;
    logic [COLOR_W-1:0] q_green_reg, q_green_next;
    logic [COLOR_W-1:0] q_blue_reg, q_blue_next;

    logic               out_valid_reg, out_valid_next;
    logic [CLASS_W-1:0] out_cls_reg, out_cls_next;
    logic [DIST_W-1:0]  out_dist_reg, out_dist_next;
    logic               out_fb_reg, out_fb_next;
    logic               out_full_reg, out_full_next;

    logic               in_ready;
    logic               accept;
    logic               have_room;
    logic               scan_last;
    logic               wr_en;
    npcc_entry_t        wr_data;
    npcc_tag_t          rd_tag;
    npcc_entry_t        rd_data;
    npcc_tag_t          rd_tag_q;
    npcc_best_t         best;

    // The result register may be refilled in the same cycle that its request is taken.
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || result.ready);
    assign accept    = item.valid && in_ready;
    assign have_room = count_reg < CNT_W'(TABLE_DEPTH);
    assign scan_last = CNT_W'(idx_reg) == CNT_W'(count_reg - CNT_W'(1));

    assign wr_data.red   = item.red;
    assign wr_data.green = item.green;
    assign wr_data.blue  = item.blue;
    assign wr_data.cls   = item.entry_class;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        q_red_next     = q_red_reg;
        q_green_next   = q_green_reg;
        q_blue_next    = q_blue_reg;
        out_valid_next = out_valid_reg;
        out_cls_next   = out_cls_reg;
        out_dist_next  = out_dist_reg;
        out_fb_next    = out_fb_reg;
        out_full_next  = out_full_reg;
        wr_en          = 1'b0;
        rd_tag         = '0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            // A full table drops the entry and flags it.
                            out_valid_next = 1'b1;
                            out_cls_next   = '0;
                            out_dist_next  = '0;
                            out_fb_next    = 1'b0;
                            out_full_next  = !have_room;
                            if (have_room)
                            begin
                                wr_en      = 1'b1;
                                count_next = CNT_W'(count_reg + CNT_W'(1));
                            end
                        end
                        CMD_CLASSIFY:
                        begin
                            if (count_reg == '0)
                            begin
                                // Empty table answers with the configured class.
                                out_valid_next = 1'b1;
                                out_cls_next   = fallback_reg;
                                out_dist_next  = '0;
                                out_fb_next    = 1'b1;
                                out_full_next  = 1'b0;
                            end
                            else
                            begin
                                q_red_next   = item.red;
                                q_green_next = item.green;
                                q_blue_next  = item.blue;
                                idx_next     = '0;
                                state_next   = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_tag.vld   = 1'b1;
                rd_tag.first = (idx_reg == '0);
                rd_tag.last  = scan_last;
                if (scan_last)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    idx_next = ADDR_W'(idx_reg + 1'b1);
                end
            end
            ST_WAIT:
            begin
                if (best.done)
                begin
                    out_valid_next = 1'b1;
                    out_cls_next   = best.cls;
                    out_dist_next  = best.min_dist;
                    out_fb_next    = 1'b0;
                    out_full_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            fallback_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                fallback_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        q_red_reg    <= q_red_next;
        q_green_reg  <= q_green_next;
        q_blue_reg   <= q_blue_next;
        out_cls_reg  <= out_cls_next;
        out_dist_reg <= out_dist_next;
        out_fb_reg   <= out_fb_next;
        out_full_reg <= out_full_next;
    end

    npcc_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (count_reg[ADDR_W-1:0]),
        .wr_data  (wr_data),
        .rd_addr  (idx_reg),
        .rd_tag   (rd_tag),
        .rd_data  (rd_data),
        .rd_tag_q (rd_tag_q)
    );

    npcc_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .entry   (rd_data),
        .tag     (rd_tag_q),
        .q_red   (q_red_reg),
        .q_green (q_green_reg),
        .q_blue  (q_blue_reg),
        .best    (best)
    );

    assign item.ready           = in_ready;
    assign result.valid         = out_valid_reg;
    assign result.chosen_class  = out_cls_reg;
    assign result.best_distance = out_dist_reg;
    assign result.used_fallback = out_fb_reg;
    assign result.table_full    = out_full_reg;

    // The fill count never passes the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count exceeds table depth");

    // The distance unit finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        best.done |-> (state_reg == ST_WAIT))
        else $error("scan finished outside the wait state");

    // A finished scan never lands on a result that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        best.done |-> !out_valid_reg)
        else $error("scan result would overwrite a pending result");

    // The last read of a scan leaves the scan state on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_tag.vld && rd_tag.last) |=> (state_reg == ST_WAIT))
        else $error("scan did not stop after the last entry");

    // A result never carries both the fallback and the full flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_fb_reg && out_full_reg))
        else $error("fallback and full flags set together");

endmodule

/* sv/npcc_table.sv */
// Reference color memory: one write port, one registered read port.
// Depends on npcc_pkg for the entry and tag types.
module npcc_table #(
    parameter  int TABLE_DEPTH = 64,
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  npcc_pkg::npcc_entry_t wr_data,
    input  logic [ADDR_W-1:0]     rd_addr,
    input  npcc_pkg::npcc_tag_t   rd_tag,
    output npcc_pkg::npcc_entry_t rd_data,
    output npcc_pkg::npcc_tag_t   rd_tag_q
);
    import npcc_pkg::*;

    npcc_entry_t table_mem [TABLE_DEPTH];
    npcc_entry_t rd_data_reg;
    npcc_tag_t   tag_reg;

    // The contents have no reset; only entries below the fill count are read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_tag.vld)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= rd_tag;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_tag_q = tag_reg;

endmodule

/* sv/npcc_dist.sv */
// Shared distance unit: squares the channel differences, then sums and keeps the minimum.
// Depends on npcc_pkg for the entry, tag and result types.
module npcc_dist (
    input  logic                           clk,
    input  logic                           rst_n,
    input  npcc_pkg::npcc_entry_t          entry,
    input  npcc_pkg::npcc_tag_t            tag,
    input  logic [npcc_pkg::COLOR_W-1:0]   q_red,
    input  logic [npcc_pkg::COLOR_W-1:0]   q_green,
    input  logic [npcc_pkg::COLOR_W-1:0]   q_blue,
    output npcc_pkg::npcc_best_t           best
);
    import npcc_pkg::*;

    function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic [COLOR_W-1:0] d_r, d_g, d_b;
    logic [SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;
    logic [CLASS_W-1:0] cls_a_reg;
    npcc_tag_t          tag_a_reg;
    logic [DIST_W-1:0]  sum;
    logic               take;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [CLASS_W-1:0] best_cls_reg;
    logic               done_reg;

    assign d_r = abs_diff(entry.red, q_red);
    assign d_g = abs_diff(entry.green, q_green);
    assign d_b = abs_diff(entry.blue, q_blue);

    // First stage: three narrow squares.
    always_ff @(posedge clk)
    begin
        sq_r_reg  <= {8'd0, d_r} * {8'd0, d_r};
        sq_g_reg  <= {8'd0, d_g} * {8'd0, d_g};
        sq_b_reg  <= {8'd0, d_b} * {8'd0, d_b};
        cls_a_reg <= entry.cls;
    end

    // Second stage: sum and strict compare, so the earliest entry wins a tie.
    assign sum  = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign take = tag_a_reg.vld && (tag_a_reg.first || (sum < best_dist_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_dist_reg <= sum;
            best_cls_reg  <= cls_a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            tag_a_reg <= tag;
            done_reg  <= tag_a_reg.vld && tag_a_reg.last;
        end
    end

    assign best.done     = done_reg;
    assign best.min_dist = best_dist_reg;
    assign best.cls      = best_cls_reg;

endmodule
